// ----- src/slsw_pkg.sv -----
// Shared types, constants and the character-to-segment map of the segment LCD string writer.
// No dependencies; the top level imports everything from here.
package slsw_pkg;

  // Function codes of an input item
  localparam logic [1:0] FUNC_CHAR  = 2'd0;
  localparam logic [1:0] FUNC_CMD   = 2'd1;
  localparam logic [1:0] FUNC_CLEAR = 2'd2;

  // Frame layout
  localparam int          FRAME_W      = 17;
  localparam int          ADDR_W       = 6;
  localparam logic [2:0]  WRITE_PREFIX = 3'b101;
  localparam logic [3:0]  CMD_PREFIX   = 4'b1000;
  localparam logic [4:0]  LEN_DATA     = 5'd17;
  localparam logic [4:0]  LEN_CMD      = 5'd12;
  localparam logic [7:0]  DOT_BIT      = 8'h80;

  localparam logic [7:0] DIGIT_SEGS [10] = '{
    8'h7D, 8'h60, 8'h3E, 8'h7A, 8'h63, 8'h5B, 8'h5F, 8'h70, 8'h7F, 8'h7B
  };

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_STRING,
    ST_CMD,
    ST_CLEAR
  } state_t;

  // Map one character code to its segment bits; unknown codes and space blank the digit
  function automatic logic [7:0] seg_map(input logic [7:0] c);
    logic [7:0] s;
    begin
      if (c >= 8'h30 && c <= 8'h39) begin
        s = DIGIT_SEGS[c[3:0]];
      end else begin
        unique case (c)
          8'h2A:   s = 8'h33;
          8'h7C:   s = 8'h05;
          8'h2D:   s = 8'h02;
          8'h5F:   s = 8'h08;
          default: s = 8'h00;
        endcase
      end
      return s;
    end
  endfunction

endpackage

// ----- src/segment_lcd_string_writer.sv -----
// Segment LCD string writer: collects a string, then emits one serial write frame per step.
// Depends on slsw_pkg (state type, frame constants, segment map).
//
// Channel  | Direction | Handshake          | Payload
// ---------+-----------+--------------------+----------------------------------------------
// in_      | input     | in_valid/in_stall  | func, char_code, last_char, left_pad, command
// out_     | output    | out_valid/out_stall| frame_bits, frame_len, last_frame
// cfg_     | input     | cfg_valid/cfg_ready| decimal_digits (cfg_data)
//
// Frames: a final character gives DIGITS frames, a clear item CLEAR_WORDS frames and a
//   command item one frame, one frame per cycle from the shared frame builder while the
//   output does not stall.
// Other characters give no frame. The input stalls while frames are being produced.
// Reset (rst_n, synchronous, active low) empties the string, clears the output valid flag and
//   sets decimal_digits to 0.
// A stall on the output freezes the sequencer with the frame held in the output register.
module segment_lcd_string_writer #(
  parameter int DIGITS      = 6,
  parameter int CLEAR_WORDS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  // input item channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_func,
  input  logic [7:0]  in_char_code,
  input  logic        in_last_char,
  input  logic        in_left_pad,
  input  logic [7:0]  in_command,
  // result item channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [16:0] out_frame_bits,
  output logic [4:0]  out_frame_len,
  output logic        out_last_frame,
  // configuration write channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_data
);
  import slsw_pkg::*;

  localparam int CW    = $clog2(DIGITS + 1);                 // character count
  localparam int IW    = (DIGITS > 1) ? $clog2(DIGITS) : 1;  // store index
  localparam int SW    = $clog2(2 * DIGITS + 1);             // digit position arithmetic
  localparam int STEPS = (DIGITS > CLEAR_WORDS) ? DIGITS : CLEAR_WORDS;
  localparam int SCW   = (STEPS > 1) ? $clog2(STEPS) : 1;    // frame step counter

  state_t             state_r, state_nxt;
  logic [SCW-1:0]     step_r, step_nxt;
  logic [CW-1:0]      count_r;
  logic [CW-1:0]      len_r;
  logic               left_r;
  logic [7:0]         cmd_r;
  logic [1:0]         dec_r;
  logic [7:0]         char_store_r [DIGITS];

  logic               out_valid_r, out_valid_nxt;
  logic [FRAME_W-1:0] out_bits_r;
  logic [4:0]         out_len_r;
  logic               out_last_r;

  logic               in_acc;
  logic               slot_free;
  logic               load;
  logic [CW-1:0]      count_upd;

  // frame builder
  logic [SW-1:0]      pos;
  logic [SW-1:0]      shifted;
  logic [SW-1:0]      src;
  logic               blank;
  logic [7:0]         seg;
  logic               dot;
  logic [ADDR_W-1:0]  addr;
  logic [FRAME_W-1:0] frame;
  logic [4:0]         frame_len;
  logic               frame_last;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state_r != ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign slot_free = !out_valid_r || !out_stall;

  assign count_upd = (count_r < CW'(DIGITS)) ? count_r + CW'(1) : count_r;

  // Digit being written: the rightmost digit goes first, at address zero
  assign pos     = SW'(DIGITS - 1) - SW'(step_r);
  assign shifted = pos + SW'(len_r);
  assign addr    = ADDR_W'(step_r) << 1;

  always_comb begin
    if (left_r) begin
      // leading spaces, then the kept characters
      blank = (shifted < SW'(DIGITS));
      src   = shifted - SW'(DIGITS);
    end else begin
      // kept characters, then trailing spaces
      blank = (pos >= SW'(len_r));
      src   = pos;
    end
    seg = blank ? 8'h00 : seg_map(char_store_r[src[IW-1:0]]);
    dot = (dec_r != 2'd0) && (SW'(dec_r) <= SW'(DIGITS))
          && (pos == SW'(DIGITS) - SW'(dec_r));
  end

  // Sequencer: next state and the frame for the output register
  always_comb begin
    state_nxt  = state_r;
    step_nxt   = step_r;
    frame      = '0;
    frame_len  = LEN_DATA;
    frame_last = 1'b0;
    load       = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        step_nxt = '0;
        if (in_acc) begin
          unique case (in_func)
            FUNC_CHAR:  if (in_last_char) state_nxt = ST_STRING;
            FUNC_CMD:   state_nxt = ST_CMD;
            FUNC_CLEAR: state_nxt = ST_CLEAR;
            default:    state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_STRING: begin
        frame      = {WRITE_PREFIX, addr, seg | (dot ? DOT_BIT : 8'h00)};
        frame_last = (step_r == SCW'(DIGITS - 1));
        load       = slot_free;
      end
      ST_CMD: begin
        frame      = FRAME_W'({CMD_PREFIX, cmd_r});
        frame_len  = LEN_CMD;
        frame_last = 1'b1;
        load       = slot_free;
      end
      ST_CLEAR: begin
        frame      = {WRITE_PREFIX, addr, 8'h00};
        frame_last = (step_r == SCW'(CLEAR_WORDS - 1));
        load       = slot_free;
      end
      default: state_nxt = ST_IDLE;
    endcase
    if (load) begin
      step_nxt = step_r + SCW'(1);
      if (frame_last) state_nxt = ST_IDLE;
    end
  end

  always_comb begin
    if (load) out_valid_nxt = 1'b1;
    else if (!out_stall) out_valid_nxt = 1'b0;
    else out_valid_nxt = out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Hold the decimal point setting; writes must come only while idle, which the block does not enforce
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dec_r <= 2'd0;
    end else if (cfg_valid && cfg_ready) begin
      dec_r <= cfg_data;
    end
  end

  // Character collection: append while room remains, else shift out the oldest on left padding
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (in_acc && in_func == FUNC_CHAR) begin
      count_r <= in_last_char ? '0 : count_upd;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && in_func == FUNC_CHAR) begin
      if (count_r < CW'(DIGITS)) begin
        char_store_r[count_r[IW-1:0]] <= in_char_code;
      end else if (in_left_pad) begin
        for (int i = 0; i < DIGITS - 1; i++) begin
          char_store_r[i] <= char_store_r[i + 1];
        end
        char_store_r[DIGITS - 1] <= in_char_code;
      end
      len_r  <= count_upd;
      left_r <= in_left_pad;
    end
    if (in_acc && in_func == FUNC_CMD) begin
      cmd_r <= in_command;
    end
  end

  // Output register payload
  always_ff @(posedge clk) begin
    if (load) begin
      out_bits_r <= frame;
      out_len_r  <= frame_len;
      out_last_r <= frame_last;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_frame_bits = out_bits_r;
  assign out_frame_len  = out_len_r;
  assign out_last_frame = out_last_r;

  // A command frame is always the only frame of its item
  a_cmd_last : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_frame_len == LEN_CMD |-> out_last_frame)
    else $error("command frame not marked last");

  // Only the two frame lengths ever leave the block
  a_len_legal : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_frame_len == LEN_CMD || out_frame_len == LEN_DATA))
    else $error("illegal frame length");

  // The string step never runs past the last digit
  a_step_range : assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_STRING |-> (32'(step_r) < DIGITS))
    else $error("string step out of range");

  // The character count never exceeds the digit count
  a_count_range : assert property (@(posedge clk) disable iff (!rst_n)
    32'(count_r) <= DIGITS)
    else $error("character count overflow");

  // A new item is never taken while frames are still being produced
  a_no_accept_busy : assert property (@(posedge clk) disable iff (!rst_n)
    load && !frame_last |=> !in_acc)
    else $error("item accepted mid-sequence");

endmodule
